// ===== sv/hrf_pkg.sv =====
// Shared types, constants and per-byte parse functions for the HTTP request head framer.
// No dependencies; used by hrf_core, hrf_out_reg and http_request_head_framer.
`default_nettype none
package hrf_pkg;

    localparam int HEAD_LIMIT_W = 16;
    localparam int BODY_LIMIT_W = 32;
    localparam logic [HEAD_LIMIT_W-1:0] HEAD_LIMIT_RESET = 16'd8192;
    localparam logic [BODY_LIMIT_W-1:0] BODY_LIMIT_RESET = 32'd1048576;

    // Configuration register indexes
    localparam logic REG_HEAD_LIMIT = 1'b0;
    localparam logic REG_BODY_LIMIT = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_COMPLETE  = 2'd0;
    localparam logic [1:0] ST_BAD       = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [23:0] CRLFCR  = 24'h0D0A0D;

    localparam logic [16:0] NONE_POS = 17'h10000;
    localparam logic [4:0]  NAME_LEN = 5'd14;
    localparam logic [4:0]  NAME_IDX_MAX = 5'd31;
    localparam logic [3:0]  MAX_DIGITS = 4'd10;

    // Header value scanner states
    localparam logic [1:0] VS_LEAD  = 2'd0;
    localparam logic [1:0] VS_DIGIT = 2'd1;
    localparam logic [1:0] VS_TRAIL = 2'd2;
    localparam logic [1:0] VS_BAD   = 2'd3;

    typedef struct packed {
        logic [16:0] first_space;
        logic [16:0] last_space;
        logic [16:0] first_question;
        logic [4:0]  name_index;
        logic        name_match;
        logic        colon_seen;
        logic [1:0]  value_state;
        logic [3:0]  value_digits;
        logic [33:0] value_accum;
    } parse_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] method_length;
        logic [15:0] target_start;
        logic [15:0] path_length;
        logic        has_query;
        logic [15:0] query_length;
        logic [15:0] version_start;
        logic [15:0] version_length;
        logic [15:0] head_length;
        logic [31:0] body_length;
        logic [32:0] total_length;
    } res_t;

    // Lower-case header name "content-length"
    function automatic logic [7:0] name_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h63;
            5'd1:    c = 8'h6F;
            5'd2:    c = 8'h6E;
            5'd3:    c = 8'h74;
            5'd4:    c = 8'h65;
            5'd5:    c = 8'h6E;
            5'd6:    c = 8'h74;
            5'd7:    c = 8'h2D;
            5'd8:    c = 8'h6C;
            5'd9:    c = 8'h65;
            5'd10:   c = 8'h6E;
            5'd11:   c = 8'h67;
            5'd12:   c = 8'h74;
            5'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic parse_t clear_line(input parse_t p);
        parse_t r;
        r = p;
        r.name_index   = '0;
        r.name_match   = 1'b1;
        r.colon_seen   = 1'b0;
        r.value_state  = VS_LEAD;
        r.value_digits = '0;
        r.value_accum  = '0;
        return r;
    endfunction

    // One content byte of the request line or of a header line
    function automatic parse_t content_byte(input logic is_line, input logic [7:0] b,
                                            input logic [15:0] pos, input parse_t p);
        parse_t r;
        logic ws;
        logic dig;
        logic [33:0] dval;
        r    = p;
        ws   = (b == CH_SP) || (b == CH_TAB);
        dig  = (b >= 8'h30) && (b <= 8'h39);
        dval = {30'd0, b[3:0]};
        if (is_line) begin
            if (b == CH_SP) begin
                if (p.first_space == NONE_POS) r.first_space = {1'b0, pos};
                r.last_space = {1'b0, pos};
            end else if (b == CH_QM && p.first_space != NONE_POS &&
                         p.first_question == NONE_POS) begin
                r.first_question = {1'b0, pos};
            end
        end else if (!p.colon_seen) begin
            if (b == CH_COLON) begin
                r.colon_seen = 1'b1;
            end else begin
                if (!(p.name_index < NAME_LEN &&
                      (b | CASE_BIT) == name_char(p.name_index)))
                    r.name_match = 1'b0;
                if (p.name_index < NAME_IDX_MAX) r.name_index = p.name_index + 5'd1;
            end
        end else begin
            case (p.value_state)
                VS_LEAD: begin
                    if (!ws) begin
                        if (!dig) begin
                            r.value_state = VS_BAD;
                        end else begin
                            r.value_state  = VS_DIGIT;
                            r.value_accum  = dval;
                            r.value_digits = 4'd1;
                        end
                    end
                end
                VS_DIGIT: begin
                    if (ws) begin
                        r.value_state = VS_TRAIL;
                    end else if (!dig || p.value_digits >= MAX_DIGITS) begin
                        r.value_state = VS_BAD;
                    end else begin
                        // times ten as two shifts and an add
                        r.value_accum  = (p.value_accum << 3) + (p.value_accum << 1) + dval;
                        r.value_digits = p.value_digits + 4'd1;
                    end
                end
                VS_TRAIL: begin
                    if (!ws) r.value_state = VS_BAD;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/hrf_core.sv =====
// Byte-at-a-time parse state and result formation for the request head framer.
// Depends on hrf_pkg.
`default_nettype none
module hrf_core
    import hrf_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    byte_acc,
    input  wire logic [7:0]              data_byte,
    input  wire logic                    start_flag,
    input  wire logic [HEAD_LIMIT_W-1:0] head_limit,
    input  wire logic [BODY_LIMIT_W-1:0] body_limit,
    output logic                         res_valid,
    output res_t                         res
);

    typedef enum logic [1:0] {PH_WAIT, PH_LINE, PH_HEAD, PH_BODY} phase_t;

    localparam parse_t PARSE_CLEAR = '{first_space: NONE_POS, last_space: NONE_POS,
                                       first_question: NONE_POS, name_index: 5'd0,
                                       name_match: 1'b1, colon_seen: 1'b0,
                                       value_state: VS_LEAD, value_digits: 4'd0,
                                       value_accum: 34'd0};

    phase_t      phase_reg, phase_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [23:0] last3_reg, last3_next;
    parse_t      parse_reg, parse_next;
    logic [15:0] line_end_reg, line_end_next;
    logic [33:0] length_reg, length_next;
    logic        length_err_reg, length_err_next;
    logic [31:0] remain_reg, remain_next;

    logic [15:0] pos;
    logic [7:0]  prev;
    logic        blank_line;
    logic [16:0] n;

    function automatic res_t make_complete(input parse_t p, input logic [15:0] le,
                                           input logic [15:0] bc, input logic [33:0] lv);
        res_t r;
        logic [15:0] s1;
        logic [15:0] s2;
        logic [15:0] q;
        logic        hq;
        s1 = p.first_space[15:0];
        s2 = p.last_space[15:0];
        q  = p.first_question[15:0];
        hq = (p.first_question != NONE_POS) && (p.first_question < p.last_space);
        r.status         = ST_COMPLETE;
        r.method_length  = s1;
        r.target_start   = s1 + 16'd1;
        r.path_length    = hq ? (q - s1 - 16'd1) : (s2 - s1 - 16'd1);
        r.has_query      = hq;
        r.query_length   = hq ? (s2 - q - 16'd1) : 16'd0;
        r.version_start  = s2 + 16'd1;
        r.version_length = le - s2 - 16'd1;
        r.head_length    = bc;
        r.body_length    = lv[31:0];
        r.total_length   = {17'd0, bc} + lv[32:0];
        return r;
    endfunction

    function automatic res_t fail_result(input logic [1:0] st);
        res_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    // Next-state and result logic for one accepted byte
    always_comb begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        last3_next      = last3_reg;
        parse_next      = parse_reg;
        line_end_next   = line_end_reg;
        length_next     = length_reg;
        length_err_next = length_err_reg;
        remain_next     = remain_reg;
        res_valid       = 1'b0;
        res             = '0;
        pos             = '0;
        prev            = '0;
        blank_line      = 1'b0;
        n               = '0;
        if (byte_acc) begin
            if (start_flag) begin
                phase_next      = PH_LINE;
                byte_count_next = '0;
                last3_next      = '0;
                parse_next      = PARSE_CLEAR;
                line_end_next   = '0;
                length_next     = '0;
                length_err_next = 1'b0;
                remain_next     = '0;
            end
            unique case (phase_next)
                PH_BODY: begin
                    remain_next = remain_next - 32'd1;
                    if (remain_next == 32'd0) begin
                        res_valid  = 1'b1;
                        res        = make_complete(parse_next, line_end_next,
                                                   byte_count_next, length_next);
                        phase_next = PH_WAIT;
                    end
                end
                PH_LINE, PH_HEAD: begin
                    pos        = byte_count_next;
                    prev       = last3_next[7:0];
                    blank_line = (data_byte == CH_LF) && (last3_next == CRLFCR);
                    if (prev == CH_CR && data_byte == CH_LF) begin
                        // line end
                        if (phase_next == PH_LINE) begin
                            line_end_next = pos - 16'd1;
                            phase_next    = PH_HEAD;
                        end else if (parse_next.colon_seen && parse_next.name_match &&
                                     parse_next.name_index == NAME_LEN) begin
                            if (parse_next.value_state == VS_DIGIT ||
                                parse_next.value_state == VS_TRAIL)
                                length_next = parse_next.value_accum;
                            else
                                length_err_next = 1'b1;
                        end
                        parse_next = clear_line(parse_next);
                    end else begin
                        // a held CR that was not followed by LF is plain content
                        if (prev == CH_CR)
                            parse_next = content_byte(phase_next == PH_LINE, CH_CR,
                                                      pos - 16'd1, parse_next);
                        if (data_byte != CH_CR)
                            parse_next = content_byte(phase_next == PH_LINE, data_byte,
                                                      pos, parse_next);
                    end
                    last3_next      = {last3_next[15:0], data_byte};
                    n               = {1'b0, pos} + 17'd1;
                    byte_count_next = n[15:0];
                    if (blank_line) begin
                        if (parse_next.first_space == NONE_POS ||
                            parse_next.first_space == parse_next.last_space ||
                            length_err_next) begin
                            res_valid  = 1'b1;
                            res        = fail_result(ST_BAD);
                            phase_next = PH_WAIT;
                        end else if (length_next > {2'd0, body_limit}) begin
                            res_valid  = 1'b1;
                            res        = fail_result(ST_TOO_LARGE);
                            phase_next = PH_WAIT;
                        end else if (length_next == 34'd0) begin
                            res_valid  = 1'b1;
                            res        = make_complete(parse_next, line_end_next,
                                                       byte_count_next, length_next);
                            phase_next = PH_WAIT;
                        end else begin
                            remain_next = length_next[31:0];
                            phase_next  = PH_BODY;
                        end
                    end else if (n >= {1'b0, head_limit}) begin
                        res_valid  = 1'b1;
                        res        = fail_result(ST_TOO_LARGE);
                        phase_next = PH_WAIT;
                    end
                end
                default: ;
            endcase
        end
    end

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_WAIT;
            byte_count_reg <= '0;
            last3_reg      <= '0;
            parse_reg      <= PARSE_CLEAR;
            line_end_reg   <= '0;
            length_reg     <= '0;
            length_err_reg <= 1'b0;
            remain_reg     <= '0;
        end else begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            last3_reg      <= last3_next;
            parse_reg      <= parse_next;
            line_end_reg   <= line_end_next;
            length_reg     <= length_next;
            length_err_reg <= length_err_next;
            remain_reg     <= remain_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/hrf_out_reg.sv =====
// Result register of the request head framer: holds one result until transfer.
// Depends on hrf_pkg.
`default_nettype none
module hrf_out_reg
    import hrf_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic res_valid,
    input  wire res_t res,
    input  wire logic m_ready,
    output logic      m_valid,
    output res_t      m_res,
    output logic      can_load
);

    logic valid_reg;
    res_t data_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = data_reg;

    // valid control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_valid) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (res_valid) data_reg <= res;
    end

endmodule
`default_nettype wire

// ===== sv/http_request_head_framer.sv =====
// Top level of the HTTP request head framer: config registers, parser core, result register.
// Depends on hrf_pkg, hrf_core and hrf_out_reg.
`default_nettype none
// One request byte is taken per clock on the s_ channel while s_ready is high,
// and the one result a message produces (complete, bad request or too large)
// shows on the m_ channel in the cycle after the byte that caused it. The input
// stalls only while a result sits unaccepted in the output register and m_ready
// is low. Bytes outside a message are dropped until one arrives with s_start_flag
// set. head_limit and body_limit are written on the cfg_wr_* port (index 0 and
// 1); the user must do so only while the block is idle, not enforced by the block.
module http_request_head_framer
    import hrf_pkg::*;
#(
    parameter logic [HEAD_LIMIT_W-1:0] HEAD_LIMIT_INIT = HEAD_LIMIT_RESET,
    parameter logic [BODY_LIMIT_W-1:0] BODY_LIMIT_INIT = BODY_LIMIT_RESET
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_index,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_start_flag,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [15:0]      m_method_length,
    output logic [15:0]      m_target_start,
    output logic [15:0]      m_path_length,
    output logic             m_has_query,
    output logic [15:0]      m_query_length,
    output logic [15:0]      m_version_start,
    output logic [15:0]      m_version_length,
    output logic [15:0]      m_head_length,
    output logic [31:0]      m_body_length,
    output logic [32:0]      m_total_length
);

    logic [HEAD_LIMIT_W-1:0] head_limit_reg;
    logic [BODY_LIMIT_W-1:0] body_limit_reg;
    logic                    res_valid;
    res_t                    res;
    res_t                    m_res;
    logic                    can_load;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_limit_reg <= HEAD_LIMIT_INIT;
            body_limit_reg <= BODY_LIMIT_INIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_HEAD_LIMIT: head_limit_reg <= cfg_wr_data[HEAD_LIMIT_W-1:0];
                REG_BODY_LIMIT: body_limit_reg <= cfg_wr_data[BODY_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = can_load;

    hrf_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_acc   (s_valid && can_load),
        .data_byte  (s_data_byte),
        .start_flag (s_start_flag),
        .head_limit (head_limit_reg),
        .body_limit (body_limit_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    hrf_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_res     (m_res),
        .can_load  (can_load)
    );

    assign m_status         = m_res.status;
    assign m_method_length  = m_res.method_length;
    assign m_target_start   = m_res.target_start;
    assign m_path_length    = m_res.path_length;
    assign m_has_query      = m_res.has_query;
    assign m_query_length   = m_res.query_length;
    assign m_version_start  = m_res.version_start;
    assign m_version_length = m_res.version_length;
    assign m_head_length    = m_res.head_length;
    assign m_body_length    = m_res.body_length;
    assign m_total_length   = m_res.total_length;

endmodule
`default_nettype wire

// ===== sv/hrf_checker.sv =====
// Port-level assertions for http_request_head_framer and the bind that attaches them.
// Depends on hrf_pkg and http_request_head_framer.
`default_nettype none
module hrf_checker
    import hrf_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [15:0] m_method_length,
    input wire logic [15:0] m_head_length,
    input wire logic [31:0] m_body_length,
    input wire logic [32:0] m_total_length
);

    // a held result stays until its transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // input side is open whenever the result register is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_COMPLETE |->
        m_method_length == 16'd0 && m_head_length == 16'd0 &&
        m_body_length == 32'd0 && m_total_length == 33'd0)
        else $error("error result with nonzero fields");

    // every result has a legal status code, and for a completed message total is head plus body
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
        (m_status == ST_COMPLETE || m_status == ST_BAD || m_status == ST_TOO_LARGE) &&
        (m_status != ST_COMPLETE ||
         m_total_length == {17'd0, m_head_length} + {1'b0, m_body_length}))
        else $error("bad total length or status");

endmodule

bind http_request_head_framer hrf_checker u_hrf_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_method_length (m_method_length),
    .m_head_length   (m_head_length),
    .m_body_length   (m_body_length),
    .m_total_length  (m_total_length)
);
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for http_request_head_framer: byte-stream requests in,
// one framing result per message out, checked against an in-bench frame predictor.
// Depends on hrf_pkg and the framer RTL.
`default_nettype none
module tb;
    import hrf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 4000;
    localparam int ITEM_TARGET  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {FR_WAIT, FR_LINE, FR_HEAD, FR_BODY} frame_phase_t;

    typedef struct {
        string      text;
        bit         starts;
        bit         known;
        logic [1:0] status;
    } frame_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_index;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_start_flag;
    logic        m_valid;
    logic        m_ready;
    res_t        got;

    http_request_head_framer u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_start_flag     (s_start_flag),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (got.status),
        .m_method_length  (got.method_length),
        .m_target_start   (got.target_start),
        .m_path_length    (got.path_length),
        .m_has_query      (got.has_query),
        .m_query_length   (got.query_length),
        .m_version_start  (got.version_start),
        .m_version_length (got.version_length),
        .m_head_length    (got.head_length),
        .m_body_length    (got.body_length),
        .m_total_length   (got.total_length)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Predictor state: configuration copy and frame parse state
    logic [15:0]  head_lim;
    logic [31:0]  body_lim;
    frame_phase_t fphase;
    logic [15:0]  byte_cnt;
    logic [23:0]  tail3;
    logic [16:0]  sp_first, sp_last, qm_first;
    logic [15:0]  eol_pos;
    logic [4:0]   name_idx;
    logic         name_ok, colon_hit;
    logic [1:0]   val_state;
    logic [3:0]   val_digits;
    logic [33:0]  val_accum, clen_value;
    logic         clen_bad;
    logic [31:0]  body_left;
    string        clen_name = "content-length";

    res_t frames_due[$];
    int   errors;
    int   items;
    bit   long_hold_req;

    task automatic report(input string what, input logic [32:0] seen, input logic [32:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, seen, want, $realtime);
        errors++;
    endtask

    task automatic reset_line();
        name_idx   = '0;
        name_ok    = 1'b1;
        colon_hit  = 1'b0;
        val_state  = VS_LEAD;
        val_digits = '0;
        val_accum  = '0;
    endtask

    task automatic reset_frame();
        byte_cnt   = '0;
        tail3      = '0;
        sp_first   = NONE_POS;
        sp_last    = NONE_POS;
        qm_first   = NONE_POS;
        eol_pos    = '0;
        reset_line();
        clen_value = '0;
        clen_bad   = 1'b0;
        body_left  = '0;
    endtask

    // One content byte of the request line or a header line
    task automatic scan_content(input logic [7:0] b, input logic [16:0] pos);
        logic ws, dig;
        ws  = (b == CH_SP) || (b == CH_TAB);
        dig = (b >= "0") && (b <= "9");
        if (fphase == FR_LINE) begin
            if (b == CH_SP) begin
                if (sp_first == NONE_POS) sp_first = pos;
                sp_last = pos;
            end else if (b == CH_QM && sp_first != NONE_POS && qm_first == NONE_POS) begin
                qm_first = pos;
            end
        end else if (!colon_hit) begin
            if (b == CH_COLON) begin
                colon_hit = 1'b1;
            end else begin
                if (!(name_idx < 14 && (b | CASE_BIT) == clen_name[name_idx]))
                    name_ok = 1'b0;
                if (name_idx < 31) name_idx++;
            end
        end else begin
            case (val_state)
                VS_LEAD: begin
                    if (!ws) begin
                        if (!dig) begin
                            val_state = VS_BAD;
                        end else begin
                            val_state  = VS_DIGIT;
                            val_accum  = 34'(b - "0");
                            val_digits = 4'd1;
                        end
                    end
                end
                VS_DIGIT: begin
                    if (ws) val_state = VS_TRAIL;
                    else if (!dig || val_digits >= 10) val_state = VS_BAD;
                    else begin
                        val_accum  = val_accum * 10 + 34'(b - "0");
                        val_digits++;
                    end
                end
                VS_TRAIL: if (!ws) val_state = VS_BAD;
                default: ;
            endcase
        end
    endtask

    task automatic close_line(input logic [16:0] cr_pos);
        if (fphase == FR_LINE) begin
            eol_pos = cr_pos[15:0];
            fphase  = FR_HEAD;
        end else if (colon_hit && name_ok && name_idx == 14) begin
            if (val_state == VS_DIGIT || val_state == VS_TRAIL) clen_value = val_accum;
            else clen_bad = 1'b1;
        end
        reset_line();
    endtask

    // Completed frame: request line layout and lengths
    task automatic frame_done(output res_t r);
        logic hq;
        hq = (qm_first != NONE_POS) && (qm_first < sp_last);
        r = '0;
        r.status         = ST_COMPLETE;
        r.method_length  = sp_first[15:0];
        r.target_start   = sp_first[15:0] + 16'd1;
        r.path_length    = hq ? 16'(qm_first - sp_first - 1) : 16'(sp_last - sp_first - 1);
        r.has_query      = hq;
        r.query_length   = hq ? 16'(sp_last - qm_first - 1) : 16'd0;
        r.version_start  = sp_last[15:0] + 16'd1;
        r.version_length = eol_pos - sp_last[15:0] - 16'd1;
        r.head_length    = byte_cnt;
        r.body_length    = clen_value[31:0];
        r.total_length   = 33'(clen_value + 34'(byte_cnt));
        fphase = FR_WAIT;
    endtask

    // Predict the effect of one accepted byte
    task automatic frame_step(input logic [7:0] b, input logic st,
                              output logic fire, output res_t r);
        logic [16:0] pos, n;
        logic        hend;
        fire = 1'b0;
        r    = '0;
        if (st) begin
            reset_frame();
            fphase = FR_LINE;
        end
        if (fphase == FR_WAIT) return;
        if (fphase == FR_BODY) begin
            body_left--;
            if (body_left == 0) begin
                frame_done(r);
                fire = 1'b1;
            end
            return;
        end
        pos  = {1'b0, byte_cnt};
        hend = (b == CH_LF) && (tail3 == CRLFCR);
        if (tail3[7:0] == CH_CR && b == CH_LF) begin
            close_line(pos - 17'd1);
        end else begin
            if (tail3[7:0] == CH_CR) scan_content(CH_CR, pos - 17'd1);
            if (b != CH_CR) scan_content(b, pos);
        end
        tail3    = {tail3[15:0], b};
        n        = pos + 17'd1;
        byte_cnt = n[15:0];
        if (hend) begin
            if (sp_first == NONE_POS || sp_first == sp_last || clen_bad) begin
                fire = 1'b1;
                r.status = ST_BAD;
                fphase = FR_WAIT;
            end else if (clen_value > {2'b00, body_lim}) begin
                fire = 1'b1;
                r.status = ST_TOO_LARGE;
                fphase = FR_WAIT;
            end else if (clen_value == 0) begin
                frame_done(r);
                fire = 1'b1;
            end else begin
                body_left = clen_value[31:0];
                fphase = FR_BODY;
            end
        end else if (n >= {1'b0, head_lim}) begin
            fire = 1'b1;
            r.status = ST_TOO_LARGE;
            fphase = FR_WAIT;
        end
    endtask

    // Sender: bursts of transfers with random gaps; prediction at acceptance
    int burst_left;

    task automatic send_byte(input logic [7:0] b, input logic st,
                             output logic fire, output res_t r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_start_flag <= st;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        if (st || fphase != FR_WAIT) items++;
        frame_step(b, st, fire, r);
        if (fire) frames_due.push_back(r);
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] bytes[$], input bit starts,
                              output int hits, output logic [1:0] last_status);
        logic fire;
        res_t r;
        hits = 0;
        last_status = '0;
        foreach (bytes[i]) begin
            send_byte(bytes[i], starts && i == 0, fire, r);
            if (fire) begin
                hits++;
                last_status = r.status;
            end
        end
    endtask

    // Wait until no frame result is outstanding, then let the pipeline empty
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limits(input logic [15:0] hl, input logic [31:0] bl);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_HEAD_LIMIT;
        cfg_wr_data  <= {16'd0, hl};
        @(negedge aclk);
        cfg_wr_index <= REG_BODY_LIMIT;
        cfg_wr_data  <= bl;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        head_lim = hl;
        body_lim = bl;
    endtask

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range("a", "z")) ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00);
    endfunction

    // Random request: mostly well-formed with random content, some broken
    task automatic build_frame(ref logic [7:0] q[$]);
        int n, hdrs, form;
        logic [33:0] v;
        string digits;
        q.delete();
        n = $urandom_range(0, 4);
        repeat (n) q.push_back(8'($urandom_range(33, 126)));
        form = $urandom_range(0, 19);
        if (form >= 2) q.push_back(CH_SP);
        if (form >= 1) begin
            q.push_back("/");
            n = $urandom_range(0, 7);
            repeat (n) begin
                case ($urandom_range(0, 5))
                    0:       q.push_back(CH_QM);
                    1:       q.push_back(CH_SP);
                    default: q.push_back(rand_letter());
                endcase
            end
        end
        if (form >= 2) begin
            q.push_back(CH_SP);
            n = $urandom_range(0, 8);
            repeat (n) q.push_back(8'($urandom_range(33, 126)));
        end
        if ($urandom_range(0, 9) == 0) begin
            q.push_back(CH_CR);
            q.push_back(rand_letter());
        end
        q.push_back(CH_CR);
        q.push_back(CH_LF);
        hdrs = $urandom_range(0, 3);
        repeat (hdrs) begin
            if ($urandom_range(0, 2) != 0) begin
                // content-length header with random case and value shape
                for (int i = 0; i < 14; i++) begin
                    if (clen_name[i] == "-") q.push_back("-");
                    else q.push_back(8'(clen_name[i]) ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00));
                end
                if ($urandom_range(0, 9) == 0) q.push_back(rand_letter());
                q.push_back(CH_COLON);
                repeat ($urandom_range(0, 2)) q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
                case ($urandom_range(0, 9))
                    0:       v = 34'({$urandom()} % 10000000000);
                    1:       v = 34'($urandom());
                    2:       v = 34'($urandom_range(0, 200));
                    default: v = 34'($urandom_range(0, 20));
                endcase
                digits = $sformatf("%0d", v);
                if ($urandom_range(0, 14) == 0) digits = {digits, "7"};
                if ($urandom_range(0, 14) == 0) digits = {digits, "x"};
                if ($urandom_range(0, 19) == 0) digits = "";
                foreach (digits[i]) q.push_back(digits[i]);
                repeat ($urandom_range(0, 1)) q.push_back(CH_SP);
                if ($urandom_range(0, 19) == 0) q.push_back("1");
            end else begin
                repeat ($urandom_range(0, 5)) q.push_back(rand_letter());
                q.push_back(CH_COLON);
                repeat ($urandom_range(0, 6)) q.push_back(8'($urandom_range(32, 126)));
            end
            q.push_back(CH_CR);
            q.push_back(CH_LF);
        end
        q.push_back(CH_CR);
        q.push_back(CH_LF);
        // occasionally truncated so that the next start abandons it
        if ($urandom_range(0, 14) == 0) q = q[0:$urandom_range(0, q.size() - 1)];
    endtask

    // Receiver: shifting stall pattern plus one long hold-off on request
    initial begin
        int hold, pmode, pcnt;
        m_ready = 1'b0;
        hold = 0;
        pmode = 0;
        pcnt = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = 300;
            end
            if (pcnt == 0) begin
                pcnt  = $urandom_range(16, 128);
                pmode = $urandom_range(0, 3);
            end
            pcnt--;
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                case (pmode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                $display("unexpected result transfer, status %0d at %0t", got.status, $realtime);
                errors++;
            end else begin
                want = frames_due.pop_front();
                if (got.status != want.status) report("status", got.status, want.status);
                if (got.method_length != want.method_length)
                    report("method_length", got.method_length, want.method_length);
                if (got.target_start != want.target_start)
                    report("target_start", got.target_start, want.target_start);
                if (got.path_length != want.path_length)
                    report("path_length", got.path_length, want.path_length);
                if (got.has_query != want.has_query)
                    report("has_query", got.has_query, want.has_query);
                if (got.query_length != want.query_length)
                    report("query_length", got.query_length, want.query_length);
                if (got.version_start != want.version_start)
                    report("version_start", got.version_start, want.version_start);
                if (got.version_length != want.version_length)
                    report("version_length", got.version_length, want.version_length);
                if (got.head_length != want.head_length)
                    report("head_length", got.head_length, want.head_length);
                if (got.body_length != want.body_length)
                    report("body_length", got.body_length, want.body_length);
                if (got.total_length != want.total_length)
                    report("total_length", got.total_length, want.total_length);
            end
        end
    end

    // Watchdog: cycles without any transfer
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle = 0;
            else idle++;
        end
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("** http_request_head_framer: FAILED **");
        $finish;
    end

    // Directed stimulus table
    frame_row_t rows[] = '{
        '{"GET /index.html HTTP/1.1\r\nHost: a\r\n\r\n", 1, 1, ST_COMPLETE},
        '{"GET /p?x=1 HTTP/1.1\r\n\r\n", 1, 1, ST_COMPLETE},
        '{"GET /x\r\n\r\n", 1, 1, ST_BAD},
        '{"GETX\r\n\r\n", 1, 1, ST_BAD},
        '{"\r\n\r\n", 1, 1, ST_BAD},
        '{"POST /u HTTP/1.1\r\nContent-Length: 5\r\n\r\nhello", 1, 1, ST_COMPLETE},
        '{"POST /u HTTP/1.1\r\nCONTENT-length:\t 3 \r\n\r\nabc", 1, 1, ST_COMPLETE},
        '{"POST /u HTTP/1.1\r\nContent-Length: 1x\r\nContent-Length: 2\r\n\r\n", 1, 1, ST_BAD},
        '{"POST /u HTTP/1.1\r\nContent-Length: 12345678901\r\n\r\n", 1, 1, ST_BAD},
        '{"POST /u HTTP/1.1\r\nContent-Length: 2000000\r\n\r\n", 1, 1, ST_TOO_LARGE},
        '{"POST /u HTTP/1.1\r\nContent-Length: 4294967295\r\n\r\n", 1, 1, ST_TOO_LARGE},
        '{"GET /a\rb HTTP/1.1\r\n\r\n", 1, 0, ST_COMPLETE},
        '{"a?b c?d e f\r\nContent-Lengthx: 9\r\n: 1\r\n\r\n", 1, 0, ST_COMPLETE},
        '{"GET /abandoned HTT", 1, 0, ST_COMPLETE},
        '{"GET / HTTP/1.1\r\nContent-Length: 0\r\n\r\n", 1, 1, ST_COMPLETE},
        '{"xyz\r\n\r\n", 0, 0, ST_COMPLETE}
    };

    // Random phases: limits per phase, extremes included
    logic [15:0] phase_head[6] = '{16'd65535, 16'd4, 16'd40, 16'd25, 16'd100, 16'd8192};
    logic [31:0] phase_body[6] = '{32'hFFFF_FFFF, 32'd0, 32'd30, 32'hFFFF_FFFF, 32'd15, 32'd1048576};

    initial begin
        logic [7:0]  q[$];
        logic [1:0]  st;
        logic        fire;
        res_t        r;
        int          hits, budget;
        bit          hold_sent;
        string       txt;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_index  = REG_HEAD_LIMIT;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_data_byte   = '0;
        s_start_flag  = 1'b0;
        errors        = 0;
        items         = 0;
        burst_left    = 0;
        long_hold_req = 1'b0;
        hold_sent     = 1'b0;
        head_lim      = HEAD_LIMIT_RESET;
        body_lim      = BODY_LIMIT_RESET;
        fphase        = FR_WAIT;
        reset_frame();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under reset limits
        foreach (rows[i]) begin
            q.delete();
            txt = rows[i].text;
            foreach (txt[k]) q.push_back(txt[k]);
            send_frame(q, rows[i].starts, hits, st);
            if (rows[i].known && (hits != 1 || st != rows[i].status))
                report($sformatf("row %0d status", i), st, rows[i].status);
        end
        wait_drained();

        // Random part, several limit settings
        budget = ITEM_TARGET / 6;
        for (int p = 0; p < 6; p++) begin
            write_limits(phase_head[p], phase_body[p]);
            while (items < budget * (p + 1)) begin
                if (p == 2 && !hold_sent && items >= budget * 2 + 40) begin
                    long_hold_req = 1'b1;
                    hold_sent     = 1'b1;
                end
                if ($urandom_range(0, 19) == 0) begin
                    // stray bytes with no start
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom()), 1'b0, fire, r);
                end
                build_frame(q);
                send_frame(q, 1'b1, hits, st);
                // short bodies are sent in full, long ones are abandoned
                while (fphase == FR_BODY && body_left <= 64)
                    send_byte(8'($urandom()), 1'b0, fire, r);
            end
            wait_drained();
        end

        wait_drained();
        if (errors == 0) begin
            $display("** http_request_head_framer: PASSED **");
        end else begin
            $display("** http_request_head_framer: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
